[rtl/core/rtq_pkg.sv]
// Shared types and constants of the retransmit timer queue.
package rtq_pkg;

    localparam int SEQ_W   = 32;
    localparam int PORT_W  = 16;
    localparam int TIME_W  = 32;
    localparam int TMO_W   = 16;
    localparam int STEP_W  = 10;
    localparam int OPC_W   = 2;

    // Request opcodes
    localparam logic [OPC_W-1:0] OP_TICK   = 2'd0;
    localparam logic [OPC_W-1:0] OP_START  = 2'd1;
    localparam logic [OPC_W-1:0] OP_CANCEL = 2'd2;

    // Response kinds
    localparam logic KIND_EXPIRED  = 1'b0;
    localparam logic KIND_REJECTED = 1'b1;

    // Row commands
    typedef logic [1:0] cell_op_t;
    localparam cell_op_t CELL_HOLD   = 2'd0;
    localparam cell_op_t CELL_INSERT = 2'd1;
    localparam cell_op_t CELL_REMOVE = 2'd2;

    // Half range of the wrapping clock, used by the due test
    localparam logic [TIME_W-1:0] HALF_RANGE = {1'b1, {(TIME_W-1){1'b0}}};

    typedef struct packed {
        logic [SEQ_W-1:0]  seq;
        logic [PORT_W-1:0] port;
        logic [TIME_W-1:0] expiry;
    } timer_data_t;

    typedef struct packed {
        logic        valid;
        timer_data_t data;
    } timer_entry_t;

    // Command broadcast to every cell of the row
    typedef struct packed {
        cell_op_t          op;
        timer_data_t       new_data;
        logic [TMO_W-1:0]  tmo;
        logic [TIME_W-1:0] now;
    } cell_cmd_t;

endpackage

[rtl/core/rtq_req_if.sv]
// Request channel: valid/ready handshake with the request payload.
interface rtq_req_if;
    import rtq_pkg::*;

    logic              valid;
    logic              ready;
    logic [OPC_W-1:0]  opcode;
    logic [SEQ_W-1:0]  sequence_req;
    logic [PORT_W-1:0] port;
    logic [TMO_W-1:0]  timeout_ms;

    modport source (output valid, output opcode, output sequence_req, output port,
                    output timeout_ms, input ready);
    modport sink   (input valid, input opcode, input sequence_req, input port,
                    input timeout_ms, output ready);
endinterface

[rtl/core/rtq_rsp_if.sv]
// Response channel: valid/ready handshake with the response payload.
interface rtq_rsp_if;
    import rtq_pkg::*;

    logic              valid;
    logic              ready;
    logic              kind;
    logic [SEQ_W-1:0]  expired_sequence;
    logic [PORT_W-1:0] expired_port;
    logic              last;

    modport source (output valid, output kind, output expired_sequence,
                    output expired_port, output last, input ready);
    modport sink   (input valid, input kind, input expired_sequence,
                    input expired_port, input last, output ready);
endinterface

[rtl/core/retransmit_timer_queue_unit.sv]
// Top level of the retransmit timer queue: clock, control and the row of cells.
//
//  channel | dir | handshake            | word
//  --------+-----+----------------------+-----------------------------------------------
//  req     | in  | valid & ready        | opcode, sequence_req, port, timeout_ms
//  rsp     | out | valid & ready        | kind, expired_sequence, expired_port, last
//  cfg     | in  | cfg_we (no wait)     | cfg_wdata = tick_step_ms
//
//  Start and cancel act on the row directly. A tick advances the clock and then
//  releases the due timers, if any, one at a time, since every release
//  pops the head of the cell row through the single response register.
//  Reset empties the row at once and sets the clock to 0 and the step to 1.
//  A stalled response holds the row and the request channel until it is taken.
module retransmit_timer_queue_unit #(
    parameter int TABLE_DEPTH = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [rtq_pkg::STEP_W-1:0]    cfg_wdata,
    rtq_req_if.sink                       req,
    rtq_rsp_if.source                     rsp
);
    import rtq_pkg::*;

    localparam logic ST_IDLE  = 1'b0;
    localparam logic ST_DRAIN = 1'b1;

    logic                state_reg;
    logic                state_next;
    logic [STEP_W-1:0]   step_reg;
    logic [TIME_W-1:0]   now_reg;
    logic [TIME_W-1:0]   now_next;

    logic                out_valid_reg;
    logic                out_valid_next;
    logic                out_kind_reg;
    logic                out_kind_next;
    logic [SEQ_W-1:0]    out_seq_reg;
    logic [SEQ_W-1:0]    out_seq_next;
    logic [PORT_W-1:0]   out_port_reg;
    logic [PORT_W-1:0]   out_port_next;
    logic                out_last_reg;
    logic                out_last_next;

    logic                slot_free;
    logic                req_fire;
    logic                out_load;
    cell_cmd_t           cmd;
    logic                pop;

    timer_entry_t        entries [TABLE_DEPTH];
    logic [TABLE_DEPTH:0] chain;
    logic [TABLE_DEPTH-1:0] due;

    assign slot_free = !out_valid_reg || rsp.ready;
    assign req.ready = (state_reg == ST_IDLE) && slot_free;
    assign req_fire  = req.valid && req.ready;

    // Decode the request or the drain step into a row command and a response
    always_comb
    begin
        state_next        = state_reg;
        now_next          = now_reg;
        out_load          = 1'b0;
        out_kind_next     = out_kind_reg;
        out_seq_next      = out_seq_reg;
        out_port_next     = out_port_reg;
        out_last_next     = out_last_reg;
        pop               = 1'b0;
        cmd.op            = CELL_HOLD;
        cmd.new_data.seq  = req.sequence_req;
        cmd.new_data.port = req.port;
        cmd.new_data.expiry = now_reg + {{(TIME_W-TMO_W){1'b0}}, req.timeout_ms};
        cmd.tmo           = req.timeout_ms;
        cmd.now           = now_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (req_fire)
                begin
                    case (req.opcode)
                        OP_TICK:
                        begin
                            now_next   = now_reg + {{(TIME_W-STEP_W){1'b0}}, step_reg};
                            state_next = ST_DRAIN;
                        end
                        OP_START:
                        begin
                            if (entries[TABLE_DEPTH-1].valid)
                            begin
                                out_load      = 1'b1;
                                out_kind_next = KIND_REJECTED;
                                out_seq_next  = req.sequence_req;
                                out_port_next = req.port;
                                out_last_next = 1'b1;
                            end
                            else
                            begin
                                cmd.op = CELL_INSERT;
                            end
                        end
                        OP_CANCEL:
                        begin
                            cmd.op = CELL_REMOVE;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            ST_DRAIN:
            begin
                if (slot_free)
                begin
                    if (due[0])
                    begin
                        // Release the head timer and pop the row
                        out_load      = 1'b1;
                        out_kind_next = KIND_EXPIRED;
                        out_seq_next  = entries[0].data.seq;
                        out_port_next = entries[0].data.port;
                        out_last_next = !due[1];
                        cmd.op        = CELL_REMOVE;
                        pop           = 1'b1;
                        if (!due[1])
                        begin
                            state_next = ST_IDLE;
                        end
                    end
                    else
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Build the row of cells; a pop forces removal from the head
    assign chain[0] = pop;

    generate
        for (genvar i = 0; i < TABLE_DEPTH; i++)
        begin : g_cell
            timer_entry_t left_entry;
            timer_entry_t right_entry;

            if (i == 0)
            begin : g_first
                assign left_entry = '0;
            end
            else
            begin : g_inner_left
                assign left_entry = entries[i-1];
            end

            if (i == TABLE_DEPTH - 1)
            begin : g_last
                assign right_entry = '0;
            end
            else
            begin : g_inner_right
                assign right_entry = entries[i+1];
            end

            rtq_cell u_cell (
                .clk         (clk),
                .rst_n       (rst_n),
                .cmd         (cmd),
                .left_entry  (left_entry),
                .right_entry (right_entry),
                .chain_in    (chain[i]),
                .chain_out   (chain[i+1]),
                .entry       (entries[i]),
                .due         (due[i])
            );
        end
    endgenerate

    // Hold the response until taken
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (rsp.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    assign rsp.valid            = out_valid_reg;
    assign rsp.kind             = out_kind_reg;
    assign rsp.expired_sequence = out_seq_reg;
    assign rsp.expired_port     = out_port_reg;
    assign rsp.last             = out_last_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            step_reg      <= STEP_W'(1);
            now_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            now_reg       <= now_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we)
            begin
                step_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        out_kind_reg <= out_kind_next;
        out_seq_reg  <= out_seq_next;
        out_port_reg <= out_port_next;
        out_last_reg <= out_last_next;
    end

endmodule

[rtl/core/rtq_cell.sv]
// One slot of the sorted timer row: holds a timer and shifts with its neighbors.
module rtq_cell (
    input  logic                  clk,
    input  logic                  rst_n,
    input  rtq_pkg::cell_cmd_t    cmd,
    input  rtq_pkg::timer_entry_t left_entry,
    input  rtq_pkg::timer_entry_t right_entry,
    input  logic                  chain_in,
    output logic                  chain_out,
    output rtq_pkg::timer_entry_t entry,
    output logic                  due
);
    import rtq_pkg::*;

    logic               valid_reg;
    logic               valid_next;
    timer_data_t        data_reg;
    timer_data_t        data_next;
    logic [TIME_W-1:0]  remain;
    logic               mark;
    logic               match;
    logic               local_hit;

    // Time left until expiry, relative to the current clock
    assign remain = data_reg.expiry - cmd.now;

    // Insert point: empty slot or a timer that expires strictly later
    assign mark  = !valid_reg || (remain > {{(TIME_W-TMO_W){1'b0}}, cmd.tmo});
    assign match = valid_reg && (data_reg.seq == cmd.new_data.seq)
                             && (data_reg.port == cmd.new_data.port);
    assign due   = valid_reg && ((remain == '0) || (remain > HALF_RANGE));

    assign local_hit = (cmd.op == CELL_INSERT) ? mark : match;
    assign chain_out = chain_in || local_hit;

    assign entry.valid = valid_reg;
    assign entry.data  = data_reg;

    // Select the next content: keep, take a neighbor, or take the new timer
    always_comb
    begin
        valid_next = valid_reg;
        data_next  = data_reg;
        case (cmd.op)
            CELL_INSERT:
            begin
                if (chain_in)
                begin
                    valid_next = left_entry.valid;
                    data_next  = left_entry.data;
                end
                else if (mark)
                begin
                    valid_next = 1'b1;
                    data_next  = cmd.new_data;
                end
            end
            CELL_REMOVE:
            begin
                if (chain_out)
                begin
                    valid_next = right_entry.valid;
                    data_next  = right_entry.data;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

endmodule
